[sv/dimc_pkg.sv]
// ----------------------------------------------------------------------------
// dimc_pkg
// Shared types and constants of the icon toggle / move count block.
// ----------------------------------------------------------------------------
`default_nettype none

package dimc_pkg;

  // payload field widths
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int OUT_W      = 11;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_W  = 6;

  localparam logic [CFG_AW-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_NUM_COLS = 1'b1;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_TOGGLE = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LEAF,
    S_UP,
    S_QC_RUN,
    S_QC_END,
    S_QD_INIT,
    S_QD_RUN,
    S_QD_END,
    S_OUT
  } dimc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clearing pass, one tree word per cycle
    logic capture;   // latch the accepted item
    logic leaf_rd;   // read the leaf of the item's cell
    logic up_start;  // write leaf, read its parent
    logic up_step;   // one read-modify-write per tree level
    logic q_start;   // start a prefix walk
    logic q_sel_c;   // prefix length: cells in use (1) or the last sum (0)
    logic q_step;    // one tree level of the prefix walk
    logic save_c;    // keep the total of filled cells
    logic out_load;  // load the result register
  } dimc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic is_toggle;
    logic up_last;
    logic q_last;
    logic out_free;
  } dimc_stat_t;

endpackage

`default_nettype wire

[sv/dimc_ctrl.sv]
// ----------------------------------------------------------------------------
// dimc_ctrl
// Sequencer: clearing pass, leaf update, path update and two prefix walks.
// ----------------------------------------------------------------------------
`default_nettype none

module dimc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire dimc_pkg::dimc_stat_t stat,
  output dimc_pkg::dimc_cmd_t     cmd
);
  import dimc_pkg::*;

  dimc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.in_range) begin
          cmd.leaf_rd = 1'b1;
          state_nxt   = S_LEAF;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LEAF: begin
        cmd.up_start = 1'b1;
        state_nxt    = S_UP;
      end
      S_UP: begin
        cmd.up_step = 1'b1;
        if (stat.up_last) begin
          if (stat.is_toggle) begin
            cmd.q_start = 1'b1;
            cmd.q_sel_c = 1'b1;
            state_nxt   = S_QC_RUN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_QC_RUN: begin
        cmd.q_step = 1'b1;
        if (stat.q_last) state_nxt = S_QC_END;
      end
      S_QC_END: begin
        state_nxt = S_QD_INIT;
      end
      S_QD_INIT: begin
        cmd.save_c  = 1'b1;
        cmd.q_start = 1'b1;
        state_nxt   = S_QD_RUN;
      end
      S_QD_RUN: begin
        cmd.q_step = 1'b1;
        if (stat.q_last) state_nxt = S_QD_END;
      end
      S_QD_END: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CHECK)
    else $error("accepted item not followed by range check");

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("not ready after result load");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) && stat.clr_last |=> in_tready)
    else $error("clearing pass did not end in idle");

endmodule

`default_nettype wire

[sv/dimc_dp.sv]
// ----------------------------------------------------------------------------
// dimc_dp
// Datapath: config registers, sum tree memory, update and prefix walkers,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dimc_dp #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [dimc_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [dimc_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic [dimc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  input  wire dimc_pkg::dimc_cmd_t               cmd,
  output dimc_pkg::dimc_stat_t                   stat,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [dimc_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import dimc_pkg::*;

  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int LVL      = (CELLS <= 2) ? 1 : $clog2(CELLS);
  localparam int AW       = LVL + 1;
  localparam int TREE_N   = 2 ** AW;
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int DR_W     = $clog2(MAX_ROWS + 1);
  localparam int DC_W     = $clog2(MAX_COLS + 1);
  localparam int PROD_W   = DR_W + DC_W + 5;
  localparam int STEP_W   = $clog2(LVL + 1);
  localparam int CMP_W    = 10;
  localparam int ROWS_RST = (32 > MAX_ROWS) ? MAX_ROWS : 32;
  localparam int COLS_RST = (32 > MAX_COLS) ? MAX_COLS : 32;

  // configuration, stored already clamped
  logic [DR_W-1:0] rows_r, rows_nxt;
  logic [DC_W-1:0] cols_r, cols_nxt;

  always_comb begin
    if (cfg_wdata == '0) begin
      rows_nxt = DR_W'(1);
      cols_nxt = DC_W'(1);
    end else begin
      rows_nxt = (CMP_W'(cfg_wdata) > CMP_W'(MAX_ROWS)) ? DR_W'(MAX_ROWS)
                                                          : DR_W'(cfg_wdata);
      cols_nxt = (CMP_W'(cfg_wdata) > CMP_W'(MAX_COLS)) ? DC_W'(MAX_COLS)
                                                          : DC_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DR_W'(ROWS_RST);
      cols_r <= DC_W'(COLS_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_ROWS: rows_r <= rows_nxt;
        REG_NUM_COLS: cols_r <= cols_nxt;
        default: ;
      endcase
    end
  end

  // item capture
  logic [ROW_W-1:0]  row_in;
  logic [COL_W-1:0]  col_in;
  logic              filled_in;
  logic [PROD_W-1:0] idx_full;
  logic [PROD_W-1:0] used_full;
  logic              in_range_c;

  assign row_in    = in_tdata[ROW_W-1:0];
  assign col_in    = in_tdata[ROW_W +: COL_W];
  assign filled_in = in_tdata[ROW_W + COL_W];

  // column-major index
  assign idx_full   = PROD_W'(col_in) * PROD_W'(rows_r) + PROD_W'(row_in);
  assign used_full  = PROD_W'(rows_r) * PROD_W'(cols_r);
  assign in_range_c = (PROD_W'(row_in) < PROD_W'(rows_r)) &&
                      (PROD_W'(col_in) < PROD_W'(cols_r));

  logic           kind_r;
  logic           filled_r;
  logic           in_range_r;
  logic [LVL-1:0] idx_r;
  logic [AW-1:0]  used_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_tuser;
      filled_r   <= filled_in;
      in_range_r <= in_range_c;
      idx_r      <= LVL'(idx_full);
      used_r     <= AW'(used_full);
    end
  end

  // tree memory: root at 1, leaves at 2**LVL + index
  logic [CNT_W-1:0] tree_mem [0:TREE_N-1];
  logic [CNT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [CNT_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) tree_mem[mem_wa] <= mem_wd;
    rd_data_r <= tree_mem[mem_ra];
  end

  // clearing pass
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // leaf and path update
  logic [AW-1:0]    leaf_addr;
  logic             old_bit;
  logic             new_bit;
  logic [AW-1:0]    up_node_r;
  logic             up_inc_r;
  logic             up_dec_r;
  logic [CNT_W-1:0] up_wd;

  assign leaf_addr = {1'b1, idx_r};
  assign old_bit   = rd_data_r[0];
  assign new_bit   = (kind_r == KIND_TOGGLE) ? ~old_bit : filled_r;
  assign up_wd     = up_inc_r ? rd_data_r + CNT_W'(1) :
                     up_dec_r ? rd_data_r - CNT_W'(1) : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.up_start) begin
      up_node_r <= leaf_addr >> 1;
      up_inc_r  <= new_bit & ~old_bit;
      up_dec_r  <= old_bit & ~new_bit;
    end else if (cmd.up_step) begin
      up_node_r <= up_node_r >> 1;
    end
  end

  // prefix walk: the length's bits steer the path, left sums add in
  logic [AW-1:0]     q_len_r;
  logic [AW-1:0]     q_node_r;
  logic [STEP_W-1:0] q_step_r;
  logic              q_bit_r;
  logic              q_vld_r;
  logic [CNT_W-1:0]  acc_r;
  logic [CNT_W-1:0]  c_r;
  logic [AW-1:0]     q_addr;
  logic              q_bit;

  assign q_bit  = q_len_r[AW-1];
  assign q_addr = (q_step_r == '0) ? AW'(1) : {q_node_r[AW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      q_len_r  <= cmd.q_sel_c ? used_r : AW'(acc_r);
      q_node_r <= AW'(1);
      q_step_r <= '0;
      q_vld_r  <= 1'b0;
      acc_r    <= '0;
    end else begin
      q_vld_r <= cmd.q_step;
      if (cmd.q_step) begin
        q_len_r  <= q_len_r << 1;
        q_step_r <= q_step_r + STEP_W'(1);
        q_bit_r  <= q_bit;
        if (q_step_r != '0) q_node_r <= {q_node_r[AW-2:0], q_bit};
      end
      if (q_vld_r && q_bit_r) acc_r <= acc_r + rd_data_r;
    end
    if (cmd.save_c) c_r <= acc_r;
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr_r;
    mem_wd = '0;
    mem_ra = q_addr;
    priority if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.leaf_rd) begin
      mem_ra = leaf_addr;
    end else if (cmd.up_start) begin
      mem_we = 1'b1;
      mem_wa = leaf_addr;
      mem_wd = CNT_W'(new_bit);
      mem_ra = leaf_addr >> 1;
    end else if (cmd.up_step) begin
      mem_we = 1'b1;
      mem_wa = up_node_r;
      mem_wd = up_wd;
      mem_ra = up_node_r >> 1;
    end else begin
      mem_ra = q_addr;
    end
  end

  // result register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_moves_r;
  logic [OUT_W-1:0] out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total_r <= OUT_W'(c_r);
      out_moves_r <= OUT_W'(c_r - acc_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2 * OUT_W)'(0), out_total_r, out_moves_r};

  assign stat.clr_last  = &clr_addr_r;
  assign stat.in_range  = in_range_r;
  assign stat.is_toggle = (kind_r == KIND_TOGGLE);
  assign stat.up_last   = (up_node_r == AW'(1));
  assign stat.q_last    = (q_step_r == STEP_W'(LVL));
  assign stat.out_free  = ~out_valid_r | out_tready;

  a_up_node_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.up_step |-> up_node_r != '0)
    else $error("path update ran past the root");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.save_c |-> acc_r <= CNT_W'(CELLS))
    else $error("filled count exceeds cell count");

  a_prefix_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> acc_r <= c_r)
    else $error("prefix sum exceeds total");

endmodule

`default_nettype wire

[sv/desktop_icon_toggle_move_count.sv]
// ----------------------------------------------------------------------------
// desktop_icon_toggle_move_count
// Grid occupancy with a sum tree: point load/toggle, total and move count.
// ----------------------------------------------------------------------------
// Channel   Dir  Ports                                 Contents
// in_       in   in_tvalid/in_tready/in_tdata/in_tuser one cell load or toggle
// out_      out  out_tvalid/out_tready/out_tdata       one result per in-range toggle
// cfg_      in   cfg_we/cfg_addr/cfg_wdata             num_rows, num_cols
//
// A toggle does one tree read-modify-write per level (L = log2 of the leaf
// count), then two prefix walks reading one tree word per level through the
// single read port. A load does only the leaf and path update; an out-of-range
// item is dropped after the range check.
// After reset a clearing pass writes the 2**(L+1) tree words with no item
// accepted. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module desktop_icon_toggle_move_count #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dimc_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [dimc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dimc_pkg::IN_DATA_W-1:0] in_tdata,   // row[4:0], col[9:5], filled[10]
  input  wire logic                           in_tuser,   // kind[0]
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [dimc_pkg::OUT_DATA_W-1:0]     out_tdata   // moves_needed[10:0], total_filled[21:11]
);
  import dimc_pkg::*;

  dimc_cmd_t  cmd;
  dimc_stat_t stat;

  dimc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dimc_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[sim/desktop_icon_toggle_move_count_tb.sv]
// ----------------------------------------------------------------------------
// desktop_icon_toggle_move_count_tb
// Self-checking bench for the grid occupancy / move count block: a directed
// table walks edge cells, empty-grid and resize cases, then random load and
// toggle traffic runs over several grid sizes against a behavioral count.
// ----------------------------------------------------------------------------
module desktop_icon_toggle_move_count_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dimc_pkg::*;

  localparam int GRID_MAX   = 32;
  localparam int CELL_COUNT = GRID_MAX * GRID_MAX;
  localparam int SETTLE_CYC = 40;   // covers a load still in flight
  localparam int NUM_PHASES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  desktop_icon_toggle_move_count dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [OUT_W-1:0] moves;
    logic [OUT_W-1:0] total;
  } move_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_AW-1:0] reg_idx;
    logic [CFG_W-1:0]  value;
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              filled;
    logic              typed;
    logic [OUT_W-1:0]  moves;
    logic [OUT_W-1:0]  total;
  } directed_row_t;

  // cfg rows: is_cfg, reg, value; item rows: kind, row, col, filled, typed result
  directed_row_t directed_rows [0:21] = '{
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd0,  5'd0,  1'b0, 1'b1, 11'd0, 11'd1},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd31, 5'd31, 1'b0, 1'b1, 11'd1, 11'd2},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd0,  5'd0,  1'b1, 1'b1, 11'd1, 11'd1},
    // grid back to empty
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd31, 5'd31, 1'b0, 1'b1, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd5,  5'd3,  1'b1, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd5,  5'd3,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd31, 5'd31, 1'b1, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd0,  5'd0,  1'b1, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd17, 5'd9,  1'b0, 1'b0, 11'd0, 11'd0},
    // zero rows reads as one, oversize cols as the max
    '{1'b1, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b1, REG_NUM_COLS, 6'd63, KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd1,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd0,  5'd31, 1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_LOAD,   5'd0,  5'd5,  1'b1, 1'b0, 11'd0, 11'd0},
    '{1'b1, REG_NUM_ROWS, 6'd63, KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b1, REG_NUM_COLS, 6'd0,  KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd0,  5'd1,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd31, 5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    // full grid again: bits beyond the small grid come back into the count
    '{1'b1, REG_NUM_ROWS, 6'd32, KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b1, REG_NUM_COLS, 6'd32, KIND_LOAD,   5'd0,  5'd0,  1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd31, 5'd31, 1'b0, 1'b0, 11'd0, 11'd0},
    '{1'b0, REG_NUM_ROWS, 6'd0,  KIND_TOGGLE, 5'd16, 5'd16, 1'b1, 1'b0, 11'd0, 11'd0}
  };

  // behavioral copy of the grid
  bit           grid_bits [0:CELL_COUNT-1];
  int unsigned  grid_rows;
  int unsigned  grid_cols;
  move_result_t pending_results [$];
  int           err_count;
  bit           calm;   // no idling on either side

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  // apply one item to the grid; queue the move count a toggle produces
  task automatic update_grid(input logic kind, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic filled,
                             output bit in_range);
    int unsigned  idx;
    int unsigned  used;
    int unsigned  total;
    int unsigned  head;
    move_result_t res;
    in_range = (row < grid_rows) && (col < grid_cols);
    if (!in_range) return;
    idx = col * grid_rows + row;
    if (kind == KIND_LOAD) begin
      grid_bits[idx] = filled;
      return;
    end
    grid_bits[idx] = ~grid_bits[idx];
    used  = grid_rows * grid_cols;
    total = 0;
    for (int i = 0; i < used; i++) total += grid_bits[i];
    head = 0;
    for (int i = 0; i < total; i++) head += grid_bits[i];
    res.moves = OUT_W'(total - head);
    res.total = OUT_W'(total);
    pending_results = {pending_results, res};
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // call at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic kind, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic filled,
                           output bit in_range);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, filled, col, row};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_grid(kind, row, col, filled, in_range);
  endtask

  // hold off the sender until every result is back and the block is quiet
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_NUM_ROWS) grid_rows = clamp_dim(value);
    else grid_cols = clamp_dim(value);
  endtask

  // result checker
  always @(posedge clk) begin
    move_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[10:0] !== want.moves)
          report_mismatch("moves_needed", out_tdata[10:0], want.moves);
        if (out_tdata[21:11] !== want.total)
          report_mismatch("total_filled", out_tdata[21:11], want.total);
      end
    end
  end

  // receiver backpressure
  always begin
    @(posedge clk);
    if (!calm && $urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("desktop_icon_toggle_move_count regression: fail");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_rows [NUM_PHASES];
    logic [CFG_W-1:0] phase_cols [NUM_PHASES];
    int               phase_items [NUM_PHASES];
    int               accepted;
    bit               in_range;
    logic             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    phase_rows  = '{6'd32, 6'd1, 6'd0,  6'd63, 6'd7, 6'd0, 6'd0, 6'd32};
    phase_cols  = '{6'd32, 6'd1, 6'd63, 6'd0,  6'd5, 6'd0, 6'd0, 6'd32};
    phase_items = '{105, 35, 95, 95, 110, 110, 110, 110};
    phase_rows[5] = CFG_W'($urandom_range(0, 63));
    phase_cols[5] = CFG_W'($urandom_range(0, 63));
    phase_rows[6] = CFG_W'($urandom_range(0, 63));
    phase_cols[6] = CFG_W'($urandom_range(0, 63));

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    err_count  = 0;
    calm       = 1'b0;
    grid_rows  = GRID_MAX;
    grid_cols  = GRID_MAX;
    foreach (grid_bits[i]) grid_bits[i] = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_block();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].kind, directed_rows[i].row, directed_rows[i].col,
                  directed_rows[i].filled, in_range);
        // hand-typed result replaces the computed one
        if (directed_rows[i].typed)
          pending_results[$] = '{directed_rows[i].moves, directed_rows[i].total};
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      write_reg(REG_NUM_ROWS, phase_rows[p]);
      write_reg(REG_NUM_COLS, phase_cols[p]);
      calm = (p == NUM_PHASES - 1);
      accepted = 0;
      while (accepted < phase_items[p]) begin
        if (p == 2 && accepted == phase_items[p] / 2) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 15) begin
          // any coordinate: out of range on most small grids
          row = ROW_W'($urandom_range(0, 31));
          col = COL_W'($urandom_range(0, 31));
        end else begin
          row = ROW_W'($urandom_range(0, grid_rows - 1));
          col = COL_W'($urandom_range(0, grid_cols - 1));
        end
        kind = ($urandom_range(0, 9) < 6) ? KIND_TOGGLE : KIND_LOAD;
        send_item(kind, row, col, 1'($urandom_range(0, 1)), in_range);
        if (in_range) accepted++;
      end
    end

    drain_block();
    if (err_count == 0) begin
      $display("desktop_icon_toggle_move_count regression: pass");
    end else begin
      $display("desktop_icon_toggle_move_count regression: fail");
    end
    $finish;
  end

endmodule

[desktop_icon_toggle_move_count.f]
sv/dimc_pkg.sv
sv/dimc_ctrl.sv
sv/dimc_dp.sv
sv/desktop_icon_toggle_move_count.sv
sim/desktop_icon_toggle_move_count_tb.sv
